// File: rtl/troc_pkg.sv
package troc_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_REGISTER   = 2'd0,
        FUNC_UNREGISTER = 2'd1,
        FUNC_CHECK      = 2'd2
    } troc_func_t;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } troc_state_t;

    localparam int unsigned COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam int unsigned LEN_W = 32;

    // Result of one request, status in the lowest bit
    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               overlap;
        logic               status;
    } troc_result_t;

endpackage

// File: rtl/troc_ram.sv
module troc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/troc_engine.sv
module troc_engine #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  troc_pkg::troc_func_t               req_func,
    input  logic [ADDR_WIDTH-1:0]              req_addr,
    input  logic [troc_pkg::LEN_W-1:0]         req_length,
    input  logic [troc_pkg::LEN_W-1:0]         req_count,
    output logic                               res_valid,
    input  logic                               res_ready,
    output troc_pkg::troc_result_t             res
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned EW = ((ADDR_WIDTH > troc_pkg::LEN_W) ?
                                  ADDR_WIDTH : troc_pkg::LEN_W) + 1;
    localparam int unsigned MW = ADDR_WIDTH + troc_pkg::LEN_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(ENTRIES - 1);
    localparam logic [CW-1:0] END_CNT  = CW'(ENTRIES);

    troc_pkg::troc_state_t         state_reg, state_next;
    troc_pkg::troc_func_t          func_reg, func_next;
    logic [ADDR_WIDTH-1:0]         addr_reg, addr_next;
    logic [troc_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [EW-1:0]                 wend_reg;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          ev_vld_reg, ev_vld_next;
    logic [IW-1:0]                 ev_idx_reg, ev_idx_next;
    logic [troc_pkg::COUNT_W-1:0]  n_reg, n_next;
    logic                          status_reg, status_next;
    logic [ENTRIES-1:0]            valid_reg, valid_next;

    logic                          ram_we;
    logic                          ram_re;
    logic [MW-1:0]                 ram_wdata;
    logic [MW-1:0]                 ram_rdata;
    logic [IW-1:0]                 cnt_idx;

    logic [ADDR_WIDTH-1:0]         ent_start;
    logic [troc_pkg::LEN_W-1:0]    ent_size;
    logic [EW-1:0]                 ent_start_e;
    logic [EW-1:0]                 ent_end_e;
    logic [EW-1:0]                 addr_e;
    logic                          ent_hit;

    assign cnt_idx = cnt_reg[IW-1:0];

    // Start and size of every region, one entry per slot
    troc_ram #(
        .WIDTH (MW),
        .DEPTH (ENTRIES)
    ) u_region_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_idx),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {len_reg, addr_reg};

    // Compare the entry read last cycle against the request
    assign ent_start   = ram_rdata[ADDR_WIDTH-1:0];
    assign ent_size    = ram_rdata[MW-1:ADDR_WIDTH];
    assign ent_start_e = {{(EW-ADDR_WIDTH){1'b0}}, ent_start};
    assign ent_end_e   = ent_start_e + {{(EW-troc_pkg::LEN_W){1'b0}}, ent_size};
    assign addr_e      = {{(EW-ADDR_WIDTH){1'b0}}, addr_reg};

    always_comb
    begin
        if (func_reg == troc_pkg::FUNC_UNREGISTER)
        begin
            ent_hit = (ent_start == addr_reg);
        end
        else
        begin
            ent_hit = !((wend_reg <= ent_start_e) || (ent_end_e <= addr_e));
        end
    end

    // Sequencer: walk the slots one per cycle
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        ev_vld_next = 1'b0;
        ev_idx_next = ev_idx_reg;
        n_next      = n_reg;
        status_next = status_reg;
        valid_next  = valid_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        // Count a hit from the read stage, drop the slot on unregister
        if (ev_vld_reg && valid_reg[ev_idx_reg] && ent_hit)
        begin
            if (n_reg != troc_pkg::COUNT_MAX)
            begin
                n_next = n_reg + 1'b1;
            end
            if (func_reg == troc_pkg::FUNC_UNREGISTER)
            begin
                valid_next[ev_idx_reg] = 1'b0;
            end
        end

        unique case (state_reg)
            troc_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    func_next   = req_func;
                    addr_next   = req_addr;
                    cnt_next    = '0;
                    n_next      = '0;
                    status_next = 1'b0;
                    if ((req_func == troc_pkg::FUNC_CHECK) && (req_count < req_length))
                    begin
                        len_next = req_count;
                    end
                    else
                    begin
                        len_next = req_length;
                    end
                    state_next = troc_pkg::ST_RUN;
                end
            end

            troc_pkg::ST_RUN:
            begin
                unique case (func_reg)
                    troc_pkg::FUNC_REGISTER:
                    begin
                        if (!valid_reg[cnt_idx])
                        begin
                            ram_we              = 1'b1;
                            valid_next[cnt_idx] = 1'b1;
                            state_next          = troc_pkg::ST_FIN;
                        end
                        else if (cnt_reg == LAST_IDX)
                        begin
                            status_next = 1'b1;
                            state_next  = troc_pkg::ST_FIN;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end

                    troc_pkg::FUNC_UNREGISTER,
                    troc_pkg::FUNC_CHECK:
                    begin
                        if (cnt_reg != END_CNT)
                        begin
                            ram_re      = 1'b1;
                            ev_vld_next = 1'b1;
                            ev_idx_next = cnt_idx;
                            cnt_next    = cnt_reg + 1'b1;
                        end
                        else if (!ev_vld_reg)
                        begin
                            state_next = troc_pkg::ST_FIN;
                        end
                    end

                    default:
                    begin
                        state_next = troc_pkg::ST_FIN;
                    end
                endcase
            end

            troc_pkg::ST_FIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = troc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = troc_pkg::ST_IDLE;
            end
        endcase
    end

    // Assemble the result
    always_comb
    begin
        res.status      = status_reg;
        res.overlap     = (func_reg == troc_pkg::FUNC_CHECK) && (n_reg != '0);
        res.match_count = n_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= troc_pkg::ST_IDLE;
            ev_vld_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ev_vld_reg <= ev_vld_next;
            valid_reg  <= valid_next;
        end
    end

    // Request payload and counters
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        addr_reg   <= addr_next;
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        ev_idx_reg <= ev_idx_next;
        n_reg      <= n_next;
        status_reg <= status_next;
        wend_reg   <= addr_e + {{(EW-troc_pkg::LEN_W){1'b0}}, len_reg};
    end

endmodule

// File: rtl/tracked_region_overlap_checker_unit.sv
// A register request walks the slots up to the first free one; unregister and check walk every
// slot; one request is in the engine at a time, and a new one is taken only once the last result
// has gone to the output register. The request rate is set by the walk over the region memory
// (one slot read per cycle, data the cycle after the read).
// Reset (rst_n, asynchronous, active low) empties the table and drops any pending result;
// region memory contents are not cleared.
module tracked_region_overlap_checker_unit #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // addr[31:0], length[63:32], count[95:64]
    input  logic [1:0]   s_axis_tuser,  // func[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // status[0], overlap[1], match_count[6:2], zero pad
);

    logic [31:0]                  in_addr;
    logic [ADDR_WIDTH-1:0]        eng_addr;
    logic                         res_valid;
    logic                         res_ready;
    troc_pkg::troc_result_t       res;
    logic                         out_valid_reg, out_valid_next;
    troc_pkg::troc_result_t       out_data_reg, out_data_next;

    assign in_addr = s_axis_tdata[31:0];

    // Fit the 32-bit address to the table's address width
    generate
        if (ADDR_WIDTH > 32)
        begin : g_addr_wide
            assign eng_addr = {{(ADDR_WIDTH-32){1'b0}}, in_addr};
        end
        else if (ADDR_WIDTH == 32)
        begin : g_addr_same
            assign eng_addr = in_addr;
        end
        else
        begin : g_addr_narrow
            assign eng_addr = in_addr[ADDR_WIDTH-1:0];
        end
    endgenerate

    troc_engine #(
        .ENTRIES    (ENTRIES),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_func   (troc_pkg::troc_func_t'(s_axis_tuser)),
        .req_addr   (eng_addr),
        .req_length (s_axis_tdata[63:32]),
        .req_count  (s_axis_tdata[95:64]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

endmodule

// File: bench/tb_tracked_region_overlap_checker_unit.sv
module tb_tracked_region_overlap_checker_unit;

    localparam int unsigned ENTRIES        = 16;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_ITEMS   = 750;
    localparam int unsigned PHASE_ITEMS    = 50;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned POOL_SIZE      = 12;

    // Mirror of the region table; predicts one result per accepted request
    class overlap_scoreboard;
        bit                     valid [ENTRIES];
        logic [31:0]            start [ENTRIES];
        logic [31:0]            size  [ENTRIES];
        troc_pkg::troc_result_t expected_q[$];
        int unsigned            errors;
        int unsigned            checked;
        int unsigned            full_seen;
        int unsigned            hit_seen;
        int unsigned            removed_seen;
        int unsigned            func_seen [4];

        // Predict the answer to one accepted request and update the table
        function void note_request(logic [1:0] f, logic [31:0] a, logic [31:0] l,
                                   logic [31:0] c);
            troc_pkg::troc_result_t r;
            bit                     placed;
            int unsigned            n;
            logic [31:0]            wlen;
            logic [32:0]            wr_end;
            logic [32:0]            rg_end;
            r      = '0;
            placed = 0;
            n      = 0;
            func_seen[f]++;
            case (f)
                troc_pkg::FUNC_REGISTER:
                begin
                    // take the lowest free slot
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!placed && !valid[i])
                        begin
                            valid[i] = 1;
                            start[i] = a;
                            size[i]  = l;
                            placed   = 1;
                        end
                    end
                    r.status = !placed;
                end
                troc_pkg::FUNC_UNREGISTER:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid[i] && start[i] == a)
                        begin
                            valid[i] = 0;
                            n++;
                        end
                    end
                    r.match_count = (n > troc_pkg::COUNT_MAX) ? troc_pkg::COUNT_MAX
                                                              : n[troc_pkg::COUNT_W-1:0];
                end
                troc_pkg::FUNC_CHECK:
                begin
                    // half-open overlap on ends one bit wider than the address
                    wlen   = (l < c) ? l : c;
                    wr_end = {1'b0, a} + {1'b0, wlen};
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        rg_end = {1'b0, start[i]} + {1'b0, size[i]};
                        if (valid[i] && !(wr_end <= {1'b0, start[i]} || rg_end <= {1'b0, a}))
                            n++;
                    end
                    r.overlap     = (n != 0);
                    r.match_count = (n > troc_pkg::COUNT_MAX) ? troc_pkg::COUNT_MAX
                                                              : n[troc_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    // unused code leaves the table alone and answers zero
                end
            endcase
            expected_q.push_back(r);
        endfunction

        // Compare one output result with the oldest prediction
        function void check_result(logic [7:0] d);
            troc_pkg::troc_result_t got;
            troc_pkg::troc_result_t want;
            got = troc_pkg::troc_result_t'(d[6:0]);
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR: result 0x%02h arrived with no pending request", d);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status || got.overlap !== want.overlap ||
                got.match_count !== want.match_count)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"ERROR: result %0d expected status=%0d overlap=%0d count=%0d,",
                              " got status=%0d overlap=%0d count=%0d"},
                             checked, want.status, want.overlap, want.match_count,
                             got.status, got.overlap, got.match_count);
            end
            if (want.status)
                full_seen++;
            if (want.overlap)
                hit_seen++;
            if (want.match_count != 0 && !want.overlap)
                removed_seen += want.match_count;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    overlap_scoreboard sb;
    bit                quiet = 0;
    int unsigned       out_stall = 0;
    int unsigned       idle_cycles = 0;
    logic [31:0]       start_pool [POOL_SIZE];

    tracked_region_overlap_checker_unit #(
        .ENTRIES    (ENTRIES),
        .ADDR_WIDTH (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Gap length: mostly none or short, a few long; none during quiet phases
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Collect results and stall the output side at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (out_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                out_stall = out_stall - 1;
            end
            else
            begin
                out_stall = pick_gap();
                if (out_stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    out_stall = out_stall - 1;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // End the run when no handshake happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic [1:0] f, input logic [31:0] a,
                                input logic [31:0] l, input logic [31:0] c);
        int unsigned g;
        g = pick_gap();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, l, a};
        s_axis_tuser  <= f;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(f, a, l, c);
    endtask

    // Size or length: mostly small, some medium, some full range
    function automatic logic [31:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        if (r < 60)
            return $urandom_range(1, 256);
        if (r < 85)
            return $urandom_range(257, 65536);
        return $urandom;
    endfunction

    // One random request weighted by the phase mix
    task automatic random_request(input int unsigned reg_pct, input int unsigned unreg_pct);
        int unsigned r;
        logic [31:0] a;
        logic [31:0] l;
        logic [31:0] c;
        r = $urandom_range(0, 99);
        c = $urandom;
        if (r < reg_pct)
        begin
            a = ($urandom_range(0, 99) < 85) ? start_pool[$urandom_range(0, POOL_SIZE-1)]
                                             : $urandom;
            send_request(troc_pkg::FUNC_REGISTER, a, pick_size(), c);
        end
        else if (r < reg_pct + unreg_pct)
        begin
            a = ($urandom_range(0, 99) < 80) ? start_pool[$urandom_range(0, POOL_SIZE-1)]
                                             : $urandom;
            send_request(troc_pkg::FUNC_UNREGISTER, a, $urandom, c);
        end
        else
        begin
            // aim the write near a known start most of the time
            if ($urandom_range(0, 99) < 70)
                a = start_pool[$urandom_range(0, POOL_SIZE-1)] + $urandom_range(0, 300) - 150;
            else
                a = $urandom;
            l = pick_size();
            if ($urandom_range(0, 99) < 70)
                c = pick_size();
            send_request(troc_pkg::FUNC_CHECK, a, l, c);
        end
    endtask

    initial
    begin
        int unsigned reg_pct;
        int unsigned unreg_pct;
        int unsigned mix;
        sb = new();

        // Hold reset, then release
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, duplicates, unknown start, unused code
        send_request(troc_pkg::FUNC_CHECK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(troc_pkg::FUNC_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(troc_pkg::FUNC_REGISTER, 32'h0, 32'h0, 32'h0);
        send_request(troc_pkg::FUNC_REGISTER, 32'h1000, 32'h10, 32'h0);
        send_request(troc_pkg::FUNC_REGISTER, 32'h1000, 32'h20, 32'h0);
        send_request(troc_pkg::FUNC_CHECK, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h2);
        send_request(troc_pkg::FUNC_CHECK, 32'h0, 32'h0, 32'h0);
        send_request(troc_pkg::FUNC_CHECK, 32'h100F, 32'h5, 32'h1);
        send_request(troc_pkg::FUNC_CHECK, 32'h1010, 32'h10, 32'h10);
        send_request(troc_pkg::FUNC_CHECK, 32'h0FF0, 32'h10, 32'h64);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(troc_pkg::FUNC_UNREGISTER, 32'h2000, 32'h0, 32'h0);
        send_request(troc_pkg::FUNC_UNREGISTER, 32'h1000, 32'h0, 32'h0);
        // fill the table and push one past full
        for (int i = 0; i < ENTRIES - 1; i++)
            send_request(troc_pkg::FUNC_REGISTER, 32'h4000 + i * 32'h100, 32'h80, 32'h0);
        send_request(troc_pkg::FUNC_CHECK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Start pool for random traffic, edges included
        start_pool[0] = 32'h0;
        start_pool[1] = 32'hFFFF_FFFF;
        start_pool[2] = 32'hFFFF_FF00;
        for (int i = 3; i < POOL_SIZE; i++)
            start_pool[i] = (i < 8) ? $urandom_range(0, 32'h0001_0000) : $urandom;

        // Random phases with changing mix; some phases run without gaps
        for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++)
        begin
            mix   = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            case (mix)
                0: begin reg_pct = 55; unreg_pct = 10; end
                1: begin reg_pct = 15; unreg_pct = 40; end
                default: begin reg_pct = 30; unreg_pct = 20; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                random_request(reg_pct, unreg_pct);
                // occasional unused code as noise
                if ($urandom_range(0, 29) == 0)
                    send_request(2'd3, $urandom, $urandom, $urandom);
            end
        end
        quiet = 0;
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for one more engine pass
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (ENTRIES + 10) @(posedge clk);

        $display("Covered %0d register, %0d unregister, %0d check, %0d unused-code requests",
                 sb.func_seen[0], sb.func_seen[1], sb.func_seen[2], sb.func_seen[3]);
        $display("Checked %0d results: %0d table-full, %0d overlapping, %0d entries removed",
                 sb.checked, sb.full_seen, sb.hit_seen, sb.removed_seen);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/troc_pkg.sv
rtl/troc_ram.sv
rtl/troc_engine.sv
rtl/tracked_region_overlap_checker_unit.sv
bench/tb_tracked_region_overlap_checker_unit.sv
